[sv/gev_pkg.sv]
// ----------------------------------------------------------------------------
// gev_pkg: shared constants for the gamepad event decoder
// Field widths, control ids, axis numbers, register indexes and dead zone defaults.
// ----------------------------------------------------------------------------
package gev_pkg;

    localparam int VAL_W   = 16;
    localparam int DZ_W    = 15;
    localparam int ID_W    = 5;
    localparam int NUM_W   = 8;
    localparam int TIME_W  = 32;
    localparam int QW      = 15;
    localparam int CNT_W   = $clog2(QW);
    localparam int REG_W   = 2;

    localparam logic [REG_W-1:0] REG_LEFT_DZ  = 2'd0;
    localparam logic [REG_W-1:0] REG_RIGHT_DZ = 2'd1;
    localparam logic [REG_W-1:0] REG_TRIG_DZ  = 2'd2;

    localparam logic [DZ_W-1:0] LEFT_DZ_RST  = 15'd7849;
    localparam logic [DZ_W-1:0] RIGHT_DZ_RST = 15'd8689;
    localparam logic [DZ_W-1:0] TRIG_DZ_RST  = 15'd30;

    localparam logic [NUM_W-1:0] AX_LEFT_X     = 8'd0;
    localparam logic [NUM_W-1:0] AX_LEFT_Y     = 8'd1;
    localparam logic [NUM_W-1:0] AX_LEFT_TRIG  = 8'd2;
    localparam logic [NUM_W-1:0] AX_RIGHT_X    = 8'd3;
    localparam logic [NUM_W-1:0] AX_RIGHT_Y    = 8'd4;
    localparam logic [NUM_W-1:0] AX_RIGHT_TRIG = 8'd5;
    localparam logic [NUM_W-1:0] AX_DPAD_H     = 8'd6;
    localparam logic [NUM_W-1:0] AX_DPAD_V     = 8'd7;

    localparam logic [ID_W-1:0] ID_STICK_LEFT = 5'd9;
    localparam logic [ID_W-1:0] ID_TRIG_LEFT  = 5'd11;
    localparam logic [ID_W-1:0] ID_DPAD_LEFT  = 5'd13;

endpackage

[sv/gev_in_if.sv]
// ----------------------------------------------------------------------------
// gev_in_if: raw gamepad event channel
// Valid/ready handshake carrying one raw event item.
// ----------------------------------------------------------------------------
interface gev_in_if;
    logic                             valid;
    logic                             ready;
    logic                             req_type;
    logic                             init_flag;
    logic [gev_pkg::NUM_W-1:0]        control_number;
    logic signed [gev_pkg::VAL_W-1:0] raw_value;
    logic [gev_pkg::TIME_W-1:0]       event_time;

    modport source (output valid, req_type, init_flag, control_number, raw_value,
                    event_time, input ready);
    modport sink (input valid, req_type, init_flag, control_number, raw_value,
                  event_time, output ready);
endinterface

[sv/gev_out_if.sv]
// ----------------------------------------------------------------------------
// gev_out_if: decoded control event channel
// Valid/ready handshake carrying one decoded result item.
// ----------------------------------------------------------------------------
interface gev_out_if #(
    parameter int BTN_W = 9
);
    logic                             valid;
    logic                             ready;
    logic [gev_pkg::ID_W-1:0]         control_id;
    logic                             key_state;
    logic signed [gev_pkg::VAL_W-1:0] stick_x;
    logic signed [gev_pkg::VAL_W-1:0] stick_y;
    logic signed [gev_pkg::VAL_W-1:0] trigger_level;
    logic [BTN_W-1:0]                 pressed_buttons;
    logic [gev_pkg::TIME_W-1:0]       out_time;

    modport source (output valid, control_id, key_state, stick_x, stick_y,
                    trigger_level, pressed_buttons, out_time, input ready);
    modport sink (input valid, control_id, key_state, stick_x, stick_y,
                  trigger_level, pressed_buttons, out_time, output ready);
endinterface

[sv/gev_div.sv]
// ----------------------------------------------------------------------------
// gev_div: radix-2 restoring divider
// One quotient bit per cycle; caller guarantees the quotient fits in QW bits.
// ----------------------------------------------------------------------------
module gev_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [2*gev_pkg::QW-1:0]    i_dividend,
    input  logic [gev_pkg::QW-1:0]      i_divisor,
    output logic                        o_done,
    output logic [gev_pkg::QW-1:0]      o_quotient
);

    logic                       r_busy;
    logic                       r_done;
    logic [gev_pkg::CNT_W-1:0]  r_cnt;
    logic [gev_pkg::QW-1:0]     r_rem;
    logic [gev_pkg::QW-1:0]     r_low;
    logic [gev_pkg::QW-1:0]     r_div;
    logic [gev_pkg::QW:0]       w_trial;
    logic                       w_fit;

    always_comb begin
        w_trial = {r_rem, r_low[gev_pkg::QW-1]};
        w_fit   = (w_trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= gev_pkg::CNT_W'(gev_pkg::QW - 1);
                r_rem  <= i_dividend[2*gev_pkg::QW-1:gev_pkg::QW];
                r_low  <= i_dividend[gev_pkg::QW-1:0];
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= w_fit ? gev_pkg::QW'(w_trial - {1'b0, r_div})
                               : w_trial[gev_pkg::QW-1:0];
                r_low <= {r_low[gev_pkg::QW-2:0], w_fit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_low;

`ifndef SYNTHESIS
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");
    a_busy_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_done))
        else $error("divider done while busy");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");
`endif

endmodule

[sv/gamepad_event_decoder.sv]
// ----------------------------------------------------------------------------
// gamepad_event_decoder: raw gamepad events to decoded control items
// Dead zone and full-scale rescale of sticks and triggers, button bitmap,
// d-pad press/release tracking.
// ----------------------------------------------------------------------------
// Flow: button and d-pad items go from accept to ST_FIN; stick/trigger
//   items pass ST_CHK, then ST_FIN if inside the zone or saturated, else
//   ST_MUL, ST_DIV (15-step serial divider) and ST_FIN. One item at a time,
//   accepted in ST_IDLE; ST_FIN holds while a result waits on o_res.ready.
// Reset (sync, active low): dead zones to defaults, all control state cleared.
// ----------------------------------------------------------------------------
module gamepad_event_decoder #(
    parameter int FULL_SCALE   = 32767,
    parameter int BUTTON_COUNT = 9
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gev_pkg::REG_W-1:0]     i_cfg_idx,
    input  logic [gev_pkg::DZ_W-1:0]      i_cfg_data,
    gev_in_if.sink                        i_evt,
    gev_out_if.source                     o_res
);

    localparam logic [gev_pkg::QW-1:0] FS = gev_pkg::QW'(FULL_SCALE);

    typedef enum logic [2:0] {
        ST_IDLE, ST_CHK, ST_MUL, ST_DIV, ST_FIN
    } t_state;

    typedef enum logic [2:0] {
        K_NONE, K_BUTTON, K_STICK, K_TRIG, K_DPAD
    } t_kind;

    t_state                         r_state;
    t_kind                          r_kind;
    logic                           r_init;
    logic [gev_pkg::NUM_W-1:0]      r_num;
    logic [gev_pkg::VAL_W-1:0]      r_val;
    logic [gev_pkg::TIME_W-1:0]     r_time;
    logic                           r_hand;
    logic                           r_comp;
    logic [gev_pkg::DZ_W-1:0]       r_dz;
    logic                           r_dead;
    logic [gev_pkg::QW-1:0]         r_diff;
    logic [2*gev_pkg::QW-1:0]       r_prod;
    logic [gev_pkg::QW-1:0]         r_q;
    logic                           r_div_start;

    logic [gev_pkg::DZ_W-1:0]       r_left_dz;
    logic [gev_pkg::DZ_W-1:0]       r_right_dz;
    logic [gev_pkg::DZ_W-1:0]       r_trig_dz;

    logic [gev_pkg::VAL_W-1:0]      r_stick [4];
    logic [gev_pkg::VAL_W-1:0]      r_trig  [2];
    logic [BUTTON_COUNT-1:0]        r_btn;
    logic [1:0]                     r_dpad_h;   // {active, positive}
    logic [1:0]                     r_dpad_v;

    logic                           r_out_valid;
    logic [gev_pkg::ID_W-1:0]       r_out_id;
    logic                           r_out_key;
    logic [gev_pkg::VAL_W-1:0]      r_out_sx;
    logic [gev_pkg::VAL_W-1:0]      r_out_sy;
    logic [gev_pkg::VAL_W-1:0]      r_out_tr;
    logic [BUTTON_COUNT-1:0]        r_out_btn;
    logic [gev_pkg::TIME_W-1:0]     r_out_time;

    t_kind                          w_kind;
    logic                           w_hand;
    logic                           w_comp;
    logic [gev_pkg::DZ_W-1:0]       w_dz;
    logic [gev_pkg::VAL_W-1:0]      w_mag;
    logic                           w_in_zone;
    logic                           w_sat;
    logic                           w_div_done;
    logic [gev_pkg::QW-1:0]         w_quo;
    logic [gev_pkg::VAL_W-1:0]      w_res;
    logic [BUTTON_COUNT-1:0]        w_mask;
    logic [BUTTON_COUNT-1:0]        n_btn;
    logic [1:0]                     w_dpad_prev;
    logic [1:0]                     n_dpad;
    logic                           w_val_zero;
    logic                           w_dead;
    logic                           w_emit;
    logic [gev_pkg::ID_W-1:0]       w_id;
    logic                           w_key;
    logic [gev_pkg::VAL_W-1:0]      w_sx;
    logic [gev_pkg::VAL_W-1:0]      w_sy;
    logic [gev_pkg::VAL_W-1:0]      w_tr;
    logic                           w_fin_go;

    // event decode at accept
    always_comb begin
        w_hand = (i_evt.control_number == gev_pkg::AX_RIGHT_X)
              || (i_evt.control_number == gev_pkg::AX_RIGHT_Y)
              || (i_evt.control_number == gev_pkg::AX_RIGHT_TRIG)
              || (i_evt.control_number == gev_pkg::AX_DPAD_V);
        w_comp = (i_evt.control_number == gev_pkg::AX_LEFT_Y)
              || (i_evt.control_number == gev_pkg::AX_RIGHT_Y);
        if (i_evt.req_type) begin
            w_kind = (i_evt.control_number < gev_pkg::NUM_W'(BUTTON_COUNT)) ? K_BUTTON
                                                                            : K_NONE;
        end else if ((i_evt.control_number == gev_pkg::AX_LEFT_X)
                  || (i_evt.control_number == gev_pkg::AX_LEFT_Y)
                  || (i_evt.control_number == gev_pkg::AX_RIGHT_X)
                  || (i_evt.control_number == gev_pkg::AX_RIGHT_Y)) begin
            w_kind = K_STICK;
        end else if ((i_evt.control_number == gev_pkg::AX_LEFT_TRIG)
                  || (i_evt.control_number == gev_pkg::AX_RIGHT_TRIG)) begin
            w_kind = K_TRIG;
        end else if ((i_evt.control_number == gev_pkg::AX_DPAD_H)
                  || (i_evt.control_number == gev_pkg::AX_DPAD_V)) begin
            w_kind = K_DPAD;
        end else begin
            w_kind = K_NONE;
        end
        if (w_kind == K_TRIG) begin
            w_dz = r_trig_dz;
        end else begin
            w_dz = w_hand ? r_right_dz : r_left_dz;
        end
    end

    // dead zone compare on the captured value
    always_comb begin
        w_mag     = r_val[gev_pkg::VAL_W-1] ? gev_pkg::VAL_W'(16'd0 - r_val) : r_val;
        w_in_zone = (w_mag < {1'b0, r_dz});
        w_sat     = (r_dz >= FS) || (w_mag >= {1'b0, FS});
    end

    // result assembly and state update values
    always_comb begin
        w_res = r_val[gev_pkg::VAL_W-1] ? gev_pkg::VAL_W'(16'd0 - {1'b0, r_q})
                                        : {1'b0, r_q};
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            w_mask[i] = (r_num == gev_pkg::NUM_W'(i));
        end
        n_btn       = r_btn;
        w_val_zero  = (r_val == '0);
        w_dpad_prev = r_hand ? r_dpad_v : r_dpad_h;
        n_dpad      = {!w_val_zero, !w_val_zero && !r_val[gev_pkg::VAL_W-1]};
        w_dead      = 1'b0;
        w_id        = '0;
        w_key       = 1'b0;
        w_sx        = '0;
        w_sy        = '0;
        w_tr        = '0;
        unique case (r_kind)
            K_BUTTON: begin
                n_btn = w_val_zero ? (r_btn & ~w_mask) : (r_btn | w_mask);
                w_id  = r_num[gev_pkg::ID_W-1:0];
                w_key = !w_val_zero;
            end
            K_STICK: begin
                w_dead = r_dead;
                w_id   = gev_pkg::ID_STICK_LEFT + gev_pkg::ID_W'(r_hand);
                if (r_hand) begin
                    w_sx = r_comp ? r_stick[2] : w_res;
                    w_sy = r_comp ? w_res : r_stick[3];
                end else begin
                    w_sx = r_comp ? r_stick[0] : w_res;
                    w_sy = r_comp ? w_res : r_stick[1];
                end
            end
            K_TRIG: begin
                w_dead = r_dead;
                w_id   = gev_pkg::ID_TRIG_LEFT + gev_pkg::ID_W'(r_hand);
                w_tr   = w_res;
            end
            K_DPAD: begin
                if (w_val_zero) begin
                    w_dead = !w_dpad_prev[1];
                    w_id   = gev_pkg::ID_DPAD_LEFT
                           + gev_pkg::ID_W'({r_hand, w_dpad_prev[0]});
                end else begin
                    w_key = 1'b1;
                    w_id  = gev_pkg::ID_DPAD_LEFT
                          + gev_pkg::ID_W'({r_hand, !r_val[gev_pkg::VAL_W-1]});
                end
            end
            default: begin
                w_dead = 1'b1;
            end
        endcase
        w_emit   = !r_init && !w_dead;
        w_fin_go = !r_out_valid || o_res.ready;
    end

    gev_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_prod),
        .i_divisor  (gev_pkg::QW'(FS - r_dz)),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
            r_left_dz   <= gev_pkg::LEFT_DZ_RST;
            r_right_dz  <= gev_pkg::RIGHT_DZ_RST;
            r_trig_dz   <= gev_pkg::TRIG_DZ_RST;
            for (int i = 0; i < 4; i++) begin
                r_stick[i] <= '0;
            end
            r_trig[0]   <= '0;
            r_trig[1]   <= '0;
            r_btn       <= '0;
            r_dpad_h    <= '0;
            r_dpad_v    <= '0;
        end else begin
            r_div_start <= (r_state == ST_MUL);
            if ((r_state == ST_FIN) && w_fin_go) begin
                r_out_valid <= w_emit;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    gev_pkg::REG_LEFT_DZ:  r_left_dz  <= i_cfg_data;
                    gev_pkg::REG_RIGHT_DZ: r_right_dz <= i_cfg_data;
                    gev_pkg::REG_TRIG_DZ:  r_trig_dz  <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_evt.valid) begin
                        r_kind  <= w_kind;
                        r_init  <= i_evt.init_flag;
                        r_num   <= i_evt.control_number;
                        r_val   <= i_evt.raw_value;
                        r_time  <= i_evt.event_time;
                        r_hand  <= w_hand;
                        r_comp  <= w_comp;
                        r_dz    <= w_dz;
                        r_state <= ((w_kind == K_STICK) || (w_kind == K_TRIG)) ? ST_CHK
                                                                               : ST_FIN;
                    end
                end
                ST_CHK: begin
                    r_dead <= w_in_zone;
                    if (w_in_zone) begin
                        r_q     <= '0;
                        r_state <= ST_FIN;
                    end else if (w_sat) begin
                        r_q     <= FS;
                        r_state <= ST_FIN;
                    end else begin
                        r_diff  <= gev_pkg::QW'(w_mag - {1'b0, r_dz});
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_prod  <= r_diff * FS;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_q     <= w_quo;
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (w_fin_go) begin
                        if (r_kind == K_STICK) begin
                            r_stick[{r_hand, r_comp}] <= w_res;
                        end
                        if (r_kind == K_TRIG) begin
                            r_trig[r_hand] <= w_res;
                        end
                        if (r_kind == K_DPAD) begin
                            if (r_hand) begin
                                r_dpad_v <= n_dpad;
                            end else begin
                                r_dpad_h <= n_dpad;
                            end
                        end
                        r_btn <= n_btn;
                        if (w_emit) begin
                            r_out_id    <= w_id;
                            r_out_key   <= w_key;
                            r_out_sx    <= w_sx;
                            r_out_sy    <= w_sy;
                            r_out_tr    <= w_tr;
                            r_out_btn   <= n_btn;
                            r_out_time  <= r_time;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_evt.ready           = (r_state == ST_IDLE);
    assign o_res.valid           = r_out_valid;
    assign o_res.control_id      = r_out_id;
    assign o_res.key_state       = r_out_key;
    assign o_res.stick_x         = r_out_sx;
    assign o_res.stick_y         = r_out_sy;
    assign o_res.trigger_level   = r_out_tr;
    assign o_res.pressed_buttons = r_out_btn;
    assign o_res.out_time        = r_out_time;

`ifndef SYNTHESIS
    a_div_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && w_div_done) |=> (r_state == ST_FIN))
        else $error("divider result not taken");
    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && r_out_valid && !o_res.ready) |=> (r_state == ST_FIN))
        else $error("item finished over a pending result");
    a_kept_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stick[0] != 16'h8000) && (r_stick[1] != 16'h8000)
        && (r_stick[2] != 16'h8000) && (r_stick[3] != 16'h8000)
        && (r_trig[0] != 16'h8000) && (r_trig[1] != 16'h8000))
        else $error("kept axis value out of range");
`endif

endmodule
